// ===== design/hbp_pkg.sv =====
// Shared types and constants for the Huffman bit packer.
// Used by hbp_ctrl, hbp_datapath and huffman_bit_packer; depends on nothing.
package hbp_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int BYTE_BITS         = 8;
    localparam int TABLE_DEPTH       = 256;
    localparam int SYM_W             = 8;
    localparam int LEN_W             = 6;
    localparam int WORD_W            = 32;
    localparam int MODE_W            = 2;
    localparam int IN_W              = MODE_W + SYM_W + WORD_W + LEN_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ENCODE = 2'd1,
        MODE_FLUSH  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // write one table entry
        logic lookup;  // read the table entry of the item's symbol
        logic flush;   // move the pending bits into the byte window
        logic merge;   // merge the looked-up code behind the pending bits
        logic emit;    // send the top byte of the window
        logic finish;  // keep the leftover bits as the new pending bits
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic byte_ready;  // at least one whole byte waits in the window
        logic out_free;    // the output register can take a byte this cycle
    } status_t;

endpackage

// ===== design/hbp_datapath.sv =====
// Datapath of the Huffman bit packer: code table, valid bits, byte window,
// pending-bit accumulator and output register. Depends on hbp_pkg.
module hbp_datapath
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [IN_W-1:0] s_tdata,
    input  cmd_t            cmd,
    output status_t         st,
    input  logic            m_tready,
    output logic            m_tvalid,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    localparam int WIN_W = MAX_CODE_BITS + BYTE_BITS;
    localparam int CNT_W = $clog2(WIN_W + 1);
    localparam int ENT_W = LEN_W + MAX_CODE_BITS;

    logic [SYM_W-1:0]  in_symbol;
    logic [WORD_W-1:0] in_code_word;
    logic [LEN_W-1:0]  in_code_length;
    logic [LEN_W-1:0]  len_sat;

    logic [ENT_W-1:0]       table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    logic [ENT_W-1:0]       rd_reg;
    logic                   rd_vld_reg;

    logic [MAX_CODE_BITS-1:0] rd_code;
    logic [LEN_W-1:0]         rd_len;
    logic [MAX_CODE_BITS-1:0] code_al;
    logic [WIN_W-1:0]         merged;

    logic [WIN_W-1:0] win_reg;
    logic [CNT_W-1:0] tot_reg;
    logic [7:0]       acc_reg;   // pending bits, left aligned, zeros below
    logic [2:0]       pend_reg;
    logic [7:0]       obyte_reg;
    logic             olast_reg;
    logic             ovalid_reg;

    assign in_symbol      = s_tdata[MODE_W +: SYM_W];
    assign in_code_word   = s_tdata[MODE_W + SYM_W +: WORD_W];
    assign in_code_length = s_tdata[MODE_W + SYM_W + WORD_W +: LEN_W];

    assign len_sat = (in_code_length > LEN_W'(MAX_CODE_BITS)) ?
                     LEN_W'(MAX_CODE_BITS) : in_code_length;

    // An entry never written since reset reads as length zero.
    assign rd_code = rd_vld_reg ? rd_reg[MAX_CODE_BITS-1:0] : '0;
    assign rd_len  = rd_vld_reg ? rd_reg[ENT_W-1 -: LEN_W] : '0;

    // Left-align the code so bits above its length fall off the top.
    assign code_al = rd_code << (LEN_W'(MAX_CODE_BITS) - rd_len);
    assign merged  = {acc_reg, {MAX_CODE_BITS{1'b0}}}
                   | ({code_al, {BYTE_BITS{1'b0}}} >> pend_reg);

    assign st.byte_ready = (tot_reg >= CNT_W'(BYTE_BITS));
    assign st.out_free   = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = olast_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            table_mem[in_symbol] <= {len_sat, in_code_word[MAX_CODE_BITS-1:0]};
        end
        if (cmd.lookup)
        begin
            rd_reg <= table_mem[in_symbol];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                vld_reg[in_symbol] <= 1'b1;
            end
            if (cmd.lookup)
            begin
                rd_vld_reg <= vld_reg[in_symbol];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            tot_reg    <= '0;
            acc_reg    <= '0;
            pend_reg   <= '0;
            ovalid_reg <= 1'b0;
            obyte_reg  <= '0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.flush)
            begin
                win_reg <= {acc_reg, {MAX_CODE_BITS{1'b0}}};
                tot_reg <= (pend_reg != 3'd0) ? CNT_W'(BYTE_BITS) : '0;
            end
            else if (cmd.merge)
            begin
                win_reg <= merged;
                tot_reg <= CNT_W'(pend_reg) + CNT_W'(rd_len);
            end
            else if (cmd.emit)
            begin
                win_reg <= win_reg << BYTE_BITS;
                tot_reg <= tot_reg - CNT_W'(BYTE_BITS);
            end

            if (cmd.finish)
            begin
                acc_reg  <= win_reg[WIN_W-1 -: 8];
                pend_reg <= tot_reg[2:0];
            end

            if (cmd.emit)
            begin
                obyte_reg  <= win_reg[WIN_W-1 -: 8];
                olast_reg  <= (tot_reg < CNT_W'(2 * BYTE_BITS));
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/hbp_ctrl.sv =====
// Controller of the Huffman bit packer: sequences load, encode and flush
// items and the byte emission loop. Depends on hbp_pkg.
module hbp_ctrl
    import hbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  mode_t       mode,
    output logic        s_tready,
    output cmd_t        cmd,
    input  status_t     st
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD:
                        begin
                            cmd.load = 1'b1;
                        end
                        MODE_ENCODE:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = ST_MERGE;
                        end
                        MODE_FLUSH:
                        begin
                            cmd.flush  = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Whole bytes leave one per cycle while the output register is free; the remainder stays pending.
                if (st.byte_ready)
                begin
                    cmd.emit = st.out_free;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/huffman_bit_packer.sv =====
// Huffman bit packer: a load item writes one table entry; an encode item looks up its
// symbol, merges its code behind the pending bits and emits 0 to 4 output bytes; a flush
// item emits one byte if bits are pending. A stalled output holds the emission. The first
// byte follows the lookup and merge of an encode item or the flush step of a flush item.
// The next item is accepted while the final byte still waits in the output register.
// Reset clears the accumulator and the 256 table valid bits at once, so every
// byte reads as length zero; there is no clearing pass. Depends on hbp_pkg.
module huffman_bit_packer
    import hbp_pkg::*;
#(
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,  // mode[1:0], symbol[9:2], code_word[41:10],
                                      // code_length[47:42]
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,  // out_byte[7:0]
    output logic            m_tlast
);

    cmd_t    cmd;
    status_t st;
    mode_t   mode;

    assign mode = mode_t'(s_tdata[MODE_W-1:0]);

    hbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .mode     (mode),
        .s_tready (s_tready),
        .cmd      (cmd),
        .st       (st)
    );

    hbp_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .st       (st),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for huffman_bit_packer: directed table, then random load/encode/flush and ignored items.
// Expected bytes come from an in-bench model of the code tables and bit accumulator.
// Depends on hbp_pkg and huffman_bit_packer only.
`timescale 1ns / 1ps

module tb;
    import hbp_pkg::*;

    localparam int MAXB         = MAX_CODE_BITS_DEF;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 320;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } packed_out_t;

    typedef struct {
        mode_t       mode;
        logic [7:0]  sym;
        logic [31:0] word;
        logic [5:0]  len;
        int          nbytes;  // -1: bytes come from the model
        logic [31:0] bytes;   // first byte in [7:0]
    } step_row_t;

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata;
    logic            m_tvalid;
    logic            m_tready;
    logic [7:0]      m_tdata;
    logic            m_tlast;

    huffman_bit_packer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Model state.
    logic [31:0] code_mem [TABLE_DEPTH];
    logic [5:0]  len_mem [TABLE_DEPTH];
    logic [7:0]  acc_bits;
    int          acc_count;

    packed_out_t expected_bytes[$];
    step_row_t   steps[$];
    logic [7:0]  loaded_syms[$];

    int  errors;
    int  bytes_checked;
    int  n_load;
    int  n_encode;
    int  n_flush;
    int  n_ignored;
    int  quiet_cycles;
    bit  calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0d ns: mismatch: %s", $time, msg);
    endtask

    // Applies one accepted item to the model and queues its bytes when keep is set.
    function automatic void encode_model(input mode_t m, input logic [7:0] sym,
                                         input logic [31:0] word, input logic [5:0] len,
                                         input bit keep);
        logic [7:0]  got [4];
        int          cnt;
        int          n;
        logic [31:0] code;
        packed_out_t r;
        cnt = 0;
        case (m)
            MODE_LOAD:
            begin
                code_mem[sym] = word & 32'((64'd1 << MAXB) - 64'd1);
                len_mem[sym]  = (len > MAXB) ? 6'(MAXB) : len;
            end
            MODE_ENCODE:
            begin
                code = code_mem[sym];
                n    = len_mem[sym];
                for (int i = n - 1; i >= 0; i--)
                begin
                    acc_bits = {acc_bits[6:0], code[i]};
                    acc_count++;
                    if (acc_count == BYTE_BITS)
                    begin
                        if (cnt < 4)
                        begin
                            got[cnt] = acc_bits;
                            cnt++;
                        end
                        acc_bits  = '0;
                        acc_count = 0;
                    end
                end
            end
            MODE_FLUSH:
            begin
                if (acc_count > 0)
                begin
                    got[0] = acc_bits << (BYTE_BITS - acc_count);
                    cnt    = 1;
                end
                acc_bits  = '0;
                acc_count = 0;
            end
            default:
            begin
            end
        endcase
        if (keep)
        begin
            for (int k = 0; k < cnt; k++)
            begin
                r.data = got[k];
                r.last = (k == cnt - 1);
                expected_bytes.push_back(r);
            end
        end
    endfunction

    task automatic add_step(input mode_t m, input logic [7:0] sym, input logic [31:0] word,
                            input logic [5:0] len, input int nbytes, input logic [31:0] bytes);
        step_row_t row;
        row.mode   = m;
        row.sym    = sym;
        row.word   = word;
        row.len    = len;
        row.nbytes = nbytes;
        row.bytes  = bytes;
        steps.push_back(row);
    endtask

    task automatic send_item(input step_row_t row);
        packed_out_t r;
        while (!calm && $urandom_range(0, 99) < 18)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.len, row.word, row.sym, row.mode};
        do
            @(posedge clk);
        while (!s_tready);
        encode_model(row.mode, row.sym, row.word, row.len, row.nbytes < 0);
        for (int k = 0; k < row.nbytes; k++)
        begin
            r.data = row.bytes[8*k +: 8];
            r.last = (k == row.nbytes - 1);
            expected_bytes.push_back(r);
        end
        case (row.mode)
            MODE_LOAD:   n_load++;
            MODE_ENCODE: n_encode++;
            MODE_FLUSH:  n_flush++;
            default:     n_ignored++;
        endcase
    endtask

    // Output checker and receiver stalls.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
            else
            begin
                if (m_tdata !== expected_bytes[0].data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              m_tdata, expected_bytes[0].data));
                if (m_tlast !== expected_bytes[0].last)
                    report_mismatch($sformatf("last %0b, expected %0b (byte %02h)",
                                              m_tlast, expected_bytes[0].last, m_tdata));
                void'(expected_bytes.pop_front());
                bytes_checked++;
            end
        end
        m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        step_row_t row;
        int        pick;
        int        sent;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        n_load        = 0;
        n_encode      = 0;
        n_flush       = 0;
        n_ignored     = 0;
        calm          = 1'b0;
        acc_bits      = '0;
        acc_count     = 0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            code_mem[i] = '0;
            len_mem[i]  = '0;
        end

        // Directed part: unloaded bytes, saturation, masking, padding, ignored mode.
        add_step(MODE_ENCODE, 8'h00, 32'h0, 6'd0, 0, 32'h0);
        add_step(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 0, 32'h0);
        add_step(MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 32'h0);
        add_step(MODE_LOAD, 8'h41, 32'h0000_00FF, 6'd8, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h41, 32'h0, 6'd0, 1, 32'h0000_00FF);
        add_step(MODE_LOAD, 8'hFF, 32'hA5A5_A5A5, 6'd32, 0, 32'h0);
        add_step(MODE_ENCODE, 8'hFF, 32'h0, 6'd0, 4, 32'hA5A5_A5A5);
        add_step(MODE_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd63, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h00, 32'h0, 6'd0, 4, 32'hFFFF_FFFF);
        add_step(MODE_LOAD, 8'h01, 32'hFFFF_FFF5, 6'd3, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h01, 32'h0, 6'd0, 0, 32'h0);
        add_step(MODE_FLUSH, 8'h00, 32'h0, 6'd0, 1, 32'h0000_00A0);
        add_step(MODE_LOAD, 8'h02, 32'hFFFF_FFFF, 6'd0, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h02, 32'h0, 6'd0, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h01, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_ENCODE, 8'h41, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_FLUSH, 8'h00, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_LOAD, 8'h80, 32'h0000_0001, 6'd1, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h80, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_ENCODE, 8'hFF, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_ENCODE, 8'hFF, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_NONE, 8'h80, 32'h1234_5678, 6'd5, 0, 32'h0);
        add_step(MODE_FLUSH, 8'h00, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_LOAD, 8'h10, 32'h1234_5678, 6'd33, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h10, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_LOAD, 8'h7F, 32'h7FFF_FFFF, 6'd31, 0, 32'h0);
        add_step(MODE_ENCODE, 8'h7F, 32'h0, 6'd0, -1, 32'h0);
        add_step(MODE_FLUSH, 8'h00, 32'h0, 6'd0, -1, 32'h0);
        loaded_syms = '{8'h41, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h10, 8'h7F};

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[i])
            send_item(steps[i]);

        // Random part: mostly encodes of loaded bytes, with reloads, flushes and noise.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            calm       = (sent >= 120 && sent < 200);
            row.nbytes = -1;
            row.bytes  = '0;
            row.sym    = 8'($urandom_range(0, 255));
            row.word   = $urandom;
            row.len    = 6'($urandom_range(0, 63));
            pick       = $urandom_range(0, 99);
            if (pick < 15)
            begin
                row.mode = MODE_LOAD;
                pick     = $urandom_range(0, 99);
                if (pick < 8)
                    row.len = 6'd0;
                else if (pick < 18)
                    row.len = 6'($urandom_range(33, 63));
                else
                    row.len = 6'($urandom_range(1, 32));
                loaded_syms.push_back(row.sym);
            end
            else if (pick < 85)
            begin
                row.mode = MODE_ENCODE;
                if ($urandom_range(0, 99) < 80)
                    row.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            else if (pick < 97)
                row.mode = MODE_FLUSH;
            else
                row.mode = MODE_NONE;
            send_item(row);
            if (row.mode != MODE_NONE)
                sent++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d loads, %0d encodes, %0d flushes and %0d ignored items",
                 n_load, n_encode, n_flush, n_ignored);
        $display("checked %0d output bytes with random stalls on both sides", bytes_checked);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
design/hbp_pkg.sv
design/hbp_datapath.sv
design/hbp_ctrl.sv
design/huffman_bit_packer.sv
dv/tb.sv
